### rtl/core/sva_pkg.sv
// ----------------------------------------------------------------------------
// sva_pkg
// shared codes and field widths of the voice allocator
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int unsigned NoteW = 7;
  localparam int unsigned VelW  = 7;
  localparam int unsigned PolyW = 3;

  localparam int unsigned DefKeySlots = 16;
  localparam int unsigned DefVoices   = 4;

  localparam logic ActNoteOn  = 1'b0;
  localparam logic ActNoteOff = 1'b1;

  localparam logic CmdStart = 1'b0;
  localparam logic CmdStop  = 1'b1;

endpackage

### rtl/core/synth_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit
// held-key table in ram, round-robin voice allocation with oldest-key stealing
// ----------------------------------------------------------------------------
// one event at a time: the next event word is taken only in the idle state,
//   once the last event's commands have left the held register
// the table ram is read once per entry, in a read state and a check state
// reset: table count, busy flags, last voice cleared, polyphony one; ram contents
//   are not cleared, entries above the count are never read
module synth_voice_allocator_unit
  import sva_pkg::*;
#(
  parameter int unsigned KEY_SLOTS = DefKeySlots,
  parameter int unsigned VOICES    = DefVoices
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,   // polyphony
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // note[6:0], velocity[13:7], zero
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // voice[1:0], command[2], voice_note[9:3],
                                     // voice_velocity[16:10], zero
  output logic        m_axis_tlast
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned PW = $clog2(VOICES + 1);
  localparam int unsigned KW = $clog2(KEY_SLOTS);
  localparam int unsigned CW = $clog2(KEY_SLOTS + 1);
  localparam int unsigned EW = NoteW + VelW + 1 + VW;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_SRCH, S_STL_RD, S_STL_CK, S_NWR,
    S_P1_RD, S_P1_CK, S_P2_RD, S_P2_CK, S_P3_RD, S_P3_CK, S_P3_WR, S_FIN
  } state_e;

  typedef struct packed {
    logic [VW-1:0]    voice;
    logic             voiced;
    logic [VelW-1:0]  vel;
    logic [NoteW-1:0] note;
  } entry_t;

  typedef struct packed {
    logic [VW-1:0]    voice;
    logic             cmd;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
  } res_t;

  state_e          state_q;
  logic            act_q;
  logic [NoteW-1:0] note_q;
  logic [VelW-1:0] vel_q;
  logic [CW-1:0]   cnt_q;
  logic [VOICES-1:0] busy_q;
  logic [VW-1:0]   last_q;
  logic [PW-1:0]   poly_q;
  logic [PW-1:0]   poly_d;
  logic [PW-1:0]   r_q;
  logic [VW-1:0]   v_q;
  logic [VW-1:0]   k_q;
  logic [VW-1:0]   newv_q;
  logic [KW-1:0]   i_q;
  logic [CW-1:0]   wp_q;
  logic [PW-1:0]   freed_q;
  logic            reasg_q;
  entry_t          ent_q;
  res_t            pend_q;
  logic            pend_v_q;
  res_t            out_q;
  logic            out_v_q;
  logic            out_last_q;

  entry_t          rd_ent;
  logic [EW-1:0]   rd_data;
  logic            we;
  logic [KW-1:0]   waddr;
  entry_t          wdata;
  logic            emit_req;
  res_t            emit_res;
  logic            can_emit;
  logic            stall;
  logic            out_load;
  logic [VW-1:0]   v_inc;

  sva_ram #(
    .Width (EW),
    .Depth (KEY_SLOTS)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (we && !stall),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (i_q),
    .rdata_o (rd_data)
  );

  assign rd_ent = entry_t'(rd_data);

  always_comb begin
    if (32'(cfg_wdata_i) > VOICES) begin
      poly_d = PW'(VOICES);
    end else if (cfg_wdata_i == 3'd0) begin
      poly_d = PW'(1);
    end else begin
      poly_d = PW'(cfg_wdata_i);
    end
  end

  assign v_inc = ((PW'(v_q) + PW'(1)) == poly_q) ? '0 : VW'(v_q + VW'(1));

  always_comb begin
    emit_req = 1'b0;
    emit_res = '{voice: rd_ent.voice, cmd: CmdStop, note: rd_ent.note, vel: rd_ent.vel};
    we       = 1'b0;
    waddr    = i_q;
    wdata    = rd_ent;
    case (state_q)
      S_STL_CK: begin
        if (rd_ent.voiced) begin
          emit_req     = 1'b1;
          we           = 1'b1;
          wdata.voiced = 1'b0;
          wdata.voice  = '0;
        end
      end
      S_NWR: begin
        emit_req = 1'b1;
        emit_res = '{voice: newv_q, cmd: CmdStart, note: note_q, vel: vel_q};
        we       = 1'b1;
        waddr    = cnt_q[KW-1:0];
        wdata    = '{voice: newv_q, voiced: 1'b1, vel: vel_q, note: note_q};
      end
      S_P1_CK: begin
        emit_req = rd_ent.voiced && (rd_ent.note == note_q);
      end
      S_P2_CK: begin
        we    = (rd_ent.note != note_q);
        waddr = wp_q[KW-1:0];
      end
      S_P3_WR: begin
        emit_req = 1'b1;
        emit_res = '{voice: v_q, cmd: CmdStart, note: ent_q.note, vel: ent_q.vel};
        we       = 1'b1;
        wdata    = '{voice: v_q, voiced: 1'b1, vel: ent_q.vel, note: ent_q.note};
      end
      default: ;
    endcase
  end

  assign can_emit = !pend_v_q || !out_v_q || m_axis_tready;
  assign stall    = emit_req && !can_emit;
  assign out_load = (emit_req && !stall && pend_v_q) ||
                    (state_q == S_FIN && pend_v_q && (!out_v_q || m_axis_tready));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      busy_q     <= '0;
      last_q     <= '0;
      poly_q     <= PW'(1);
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        poly_q <= poly_d;
      end
      if (out_v_q && m_axis_tready && !out_load) begin
        out_v_q <= 1'b0;
      end
      if (emit_req && !stall) begin
        if (pend_v_q) begin
          out_q      <= pend_q;
          out_last_q <= 1'b0;
          out_v_q    <= 1'b1;
        end
        pend_q   <= emit_res;
        pend_v_q <= 1'b1;
      end
      if (!stall) begin
        case (state_q)
          S_IDLE: begin
            if (s_axis_tvalid) begin
              act_q   <= s_axis_tuser;
              note_q  <= s_axis_tdata[6:0];
              vel_q   <= s_axis_tdata[13:7];
              reasg_q <= 1'b0;
              freed_q <= '0;
              r_q     <= PW'(last_q) + PW'(1);
              if (s_axis_tuser == ActNoteOn) begin
                state_q <= (cnt_q == CW'(KEY_SLOTS)) ? S_FIN : S_MOD;
              end else if (cnt_q == '0) begin
                state_q <= S_FIN;
              end else begin
                i_q     <= KW'(cnt_q - CW'(1));
                state_q <= S_P1_RD;
              end
            end
          end
          S_MOD: begin
            if (r_q >= poly_q) begin
              r_q <= r_q - poly_q;
            end else begin
              v_q     <= VW'(r_q);
              k_q     <= '0;
              state_q <= S_SRCH;
            end
          end
          S_SRCH: begin
            if (!busy_q[v_q]) begin
              busy_q[v_q] <= 1'b1;
              last_q      <= v_q;
              newv_q      <= v_q;
              state_q     <= reasg_q ? S_P3_WR : S_NWR;
            end else if (PW'(k_q) == poly_q - PW'(1)) begin
              newv_q <= '0;
              i_q    <= '0;
              if (reasg_q) begin
                state_q <= S_FIN;
              end else begin
                state_q <= (cnt_q == '0) ? S_NWR : S_STL_RD;
              end
            end else begin
              k_q <= k_q + VW'(1);
              v_q <= v_inc;
            end
          end
          S_STL_RD: state_q <= S_STL_CK;
          S_STL_CK: begin
            if (rd_ent.voiced) begin
              newv_q  <= rd_ent.voice;
              state_q <= S_NWR;
            end else if (CW'(i_q) + CW'(1) == cnt_q) begin
              state_q <= S_NWR;
            end else begin
              i_q     <= i_q + KW'(1);
              state_q <= S_STL_RD;
            end
          end
          S_NWR: begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_FIN;
          end
          S_P1_RD: state_q <= S_P1_CK;
          S_P1_CK: begin
            if (emit_req) begin
              busy_q[rd_ent.voice] <= 1'b0;
              freed_q              <= freed_q + PW'(1);
            end
            if (i_q == '0) begin
              wp_q    <= '0;
              state_q <= S_P2_RD;
            end else begin
              i_q     <= i_q - KW'(1);
              state_q <= S_P1_RD;
            end
          end
          S_P2_RD: state_q <= S_P2_CK;
          S_P2_CK: begin
            if (rd_ent.note != note_q) begin
              wp_q <= wp_q + CW'(1);
            end
            if (CW'(i_q) + CW'(1) == cnt_q) begin
              cnt_q <= (rd_ent.note != note_q) ? wp_q + CW'(1) : wp_q;
              if (freed_q == '0) begin
                state_q <= S_FIN;
              end else if (rd_ent.note != note_q) begin
                i_q     <= KW'(wp_q);
                state_q <= S_P3_RD;
              end else if (wp_q == '0) begin
                state_q <= S_FIN;
              end else begin
                i_q     <= KW'(wp_q - CW'(1));
                state_q <= S_P3_RD;
              end
            end else begin
              i_q     <= i_q + KW'(1);
              state_q <= S_P2_RD;
            end
          end
          S_P3_RD: state_q <= S_P3_CK;
          S_P3_CK: begin
            if (!rd_ent.voiced) begin
              ent_q   <= rd_ent;
              reasg_q <= 1'b1;
              r_q     <= PW'(last_q) + PW'(1);
              state_q <= S_MOD;
            end else if (i_q == '0) begin
              state_q <= S_FIN;
            end else begin
              i_q     <= i_q - KW'(1);
              state_q <= S_P3_RD;
            end
          end
          S_P3_WR: begin
            freed_q <= freed_q - PW'(1);
            if (freed_q == PW'(1) || i_q == '0) begin
              state_q <= S_FIN;
            end else begin
              i_q     <= i_q - KW'(1);
              state_q <= S_P3_RD;
            end
          end
          S_FIN: begin
            if (!pend_v_q) begin
              state_q <= S_IDLE;
            end else if (!out_v_q || m_axis_tready) begin
              out_q      <= pend_q;
              out_last_q <= 1'b1;
              out_v_q    <= 1'b1;
              pend_v_q   <= 1'b0;
              state_q    <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_q.vel, out_q.note, out_q.cmd, 2'(out_q.voice)};

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(KEY_SLOTS)) else $error("key count beyond table");
  a_poly_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poly_q != '0 && poly_q <= PW'(VOICES)) else $error("polyphony out of range");
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("held result left behind");
  a_pend_into_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && pend_v_q && (!out_v_q || m_axis_tready)) |=>
      (out_v_q && out_last_q)) else $error("final word not marked last");
`endif

endmodule

### rtl/core/sva_ram.sv
// ----------------------------------------------------------------------------
// sva_ram
// generic single-write, single-read ram with registered read
// ----------------------------------------------------------------------------
module sva_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### tb/tb_synth_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_synth_voice_allocator_unit
// note events go in on the slave stream and voice commands are checked on the
// master stream against a local model of the held-key table, the busy flags
// and the round-robin pointer, across several polyphony settings
// ----------------------------------------------------------------------------
module tb_synth_voice_allocator_unit;
  import sva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots    = DefKeySlots;
  localparam int unsigned NVoices  = DefVoices;
  localparam int unsigned IdleWait = 2 * Slots + NVoices + 40;
  localparam int unsigned Watchdog = 4000;

  typedef struct packed {
    logic [1:0]      voice;
    logic            command;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    logic            last;
  } voice_cmd_t;

  typedef struct {
    logic             action;
    logic [NoteW-1:0] note;
    logic [VelW-1:0]  vel;
    bit               typed;
    voice_cmd_t       cmd;
  } event_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  synth_voice_allocator_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // model state
  logic [NoteW-1:0] key_note [Slots];
  logic [VelW-1:0]  key_vel [Slots];
  bit               key_voiced [Slots];
  logic [1:0]       key_voice [Slots];
  int unsigned      held_n;
  bit               busy [NVoices];
  int unsigned      last_v;
  int unsigned      poly;

  voice_cmd_t pending_cmds [$];
  voice_cmd_t step_cmds [$];
  int  errors;
  bit  quiet;
  int  stuck;

  function automatic bit grab_voice(output logic [1:0] v);
    int unsigned c;
    c = last_v;
    for (int i = 0; i < poly; i++) begin
      c = (c + 1) % poly;
      if (!busy[c]) begin
        busy[c] = 1'b1;
        last_v = c;
        v = c[1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void push_cmd(logic [1:0] v, logic c, logic [6:0] n, logic [6:0] vel);
    voice_cmd_t r;
    r = '{voice: v, command: c, note: n, vel: vel, last: 1'b0};
    step_cmds.push_back(r);
  endfunction

  function automatic void allocate_voices(logic act, logic [6:0] n, logic [6:0] vel);
    logic [1:0] v;
    int unsigned freed;
    step_cmds.delete();
    v = '0;
    if (act == ActNoteOn) begin
      if (held_n < Slots) begin
        if (!grab_voice(v)) begin
          for (int i = 0; i < held_n; i++) begin
            if (key_voiced[i]) begin
              push_cmd(key_voice[i], CmdStop, key_note[i], key_vel[i]);
              v = key_voice[i];
              key_voiced[i] = 1'b0;
              key_voice[i] = '0;
              break;
            end
          end
        end
        key_note[held_n] = n;
        key_vel[held_n] = vel;
        key_voice[held_n] = v;
        key_voiced[held_n] = 1'b1;
        push_cmd(v, CmdStart, n, vel);
        held_n++;
      end
    end else begin
      freed = 0;
      for (int i = int'(held_n) - 1; i >= 0; i--) begin
        if (key_note[i] == n) begin
          if (key_voiced[i]) begin
            push_cmd(key_voice[i], CmdStop, key_note[i], key_vel[i]);
            busy[key_voice[i]] = 1'b0;
            freed++;
          end
          for (int j = i; j < int'(held_n) - 1; j++) begin
            key_note[j] = key_note[j+1];
            key_vel[j] = key_vel[j+1];
            key_voiced[j] = key_voiced[j+1];
            key_voice[j] = key_voice[j+1];
          end
          held_n--;
        end
      end
      for (int i = int'(held_n) - 1; freed > 0 && i >= 0; i--) begin
        if (!key_voiced[i]) begin
          if (!grab_voice(v)) break;
          key_voice[i] = v;
          key_voiced[i] = 1'b1;
          push_cmd(v, CmdStart, key_note[i], key_vel[i]);
          freed--;
        end
      end
    end
    if (step_cmds.size() > 0) step_cmds[$].last = 1'b1;
  endfunction

  task automatic send_event(event_row_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tdata = {2'b0, r.vel, r.note};
    s_axis_tuser = r.action;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    allocate_voices(r.action, r.note, r.vel);
    if (r.typed) begin
      if (step_cmds.size() != 1) begin
        $error("directed row expects one command, model gives %0d", step_cmds.size());
        errors++;
      end
      pending_cmds.push_back(r.cmd);
    end else begin
      foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic write_poly(logic [2:0] p);
    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (IdleWait) @(negedge clk_i);
    cfg_wdata_i = p;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    poly = (p > NVoices) ? NVoices : (p == 0) ? 1 : p;
  endtask

  function automatic void check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    voice_cmd_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("command word with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        check_field("voice", e.voice, m_axis_tdata[1:0]);
        check_field("command", e.command, m_axis_tdata[2]);
        check_field("voice_note", e.note, m_axis_tdata[9:3]);
        check_field("voice_velocity", e.vel, m_axis_tdata[16:10]);
        check_field("last", e.last, m_axis_tlast);
      end
    end
  end

  // output stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck >= Watchdog) begin
      $display("** synth_voice_allocator_unit: FAILED **");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  event_row_t rows [$];
  logic [6:0] note_pool [8] = '{7'd0, 7'd1, 7'd60, 7'd64, 7'd67, 7'd85, 7'd126, 7'd127};

  initial begin
    event_row_t r;
    logic [2:0] phase_poly [6] = '{3'd0, 3'd2, 3'd4, 3'd1, 3'd3, 3'd7};
    errors = 0;
    quiet = 1'b0;
    stuck = 0;
    held_n = 0;
    last_v = 0;
    poly = 1;
    foreach (busy[i]) busy[i] = 1'b0;

    // polyphony one: steal, reassign after release, unmatched release
    rows.push_back('{ActNoteOn, 7'd0, 7'd0, 1'b1, '{2'd0, CmdStart, 7'd0, 7'd0, 1'b1}});
    rows.push_back('{ActNoteOn, 7'd127, 7'd127, 1'b0, '0});
    rows.push_back('{ActNoteOff, 7'd127, 7'd127, 1'b0, '0});
    rows.push_back('{ActNoteOff, 7'd5, 7'd99, 1'b0, '0});
    rows.push_back('{ActNoteOff, 7'd0, 7'd0, 1'b1, '{2'd0, CmdStop, 7'd0, 7'd0, 1'b1}});

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_event(rows[i]);

    // full polyphony, then fill the table and one more on a full table
    write_poly(3'd7);
    rows.delete();
    for (int i = 0; i <= Slots; i++) begin
      r = '{ActNoteOn, 7'(i * 7 + 1), 7'(127 - i * 5), 1'b0, '0};
      rows.push_back(r);
    end
    foreach (rows[i]) send_event(rows[i]);

    // random phases, polyphony changes with keys still held
    foreach (phase_poly[p]) begin
      write_poly(phase_poly[p]);
      if (p == 5) quiet = 1'b1;
      for (int k = 0; k < 31; k++) begin
        r.typed = 1'b0;
        r.cmd = '0;
        r.note = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : note_pool[$urandom_range(0, 7)];
        r.vel = 7'($urandom_range(0, 127));
        if (held_n >= Slots - 2) r.action = ($urandom_range(0, 9) < 7);
        else r.action = ($urandom_range(0, 9) < 4);
        if (r.action == ActNoteOff && held_n > 0 && $urandom_range(0, 2) != 0)
          r.note = key_note[$urandom_range(0, held_n - 1)];
        send_event(r);
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (IdleWait) @(negedge clk_i);
    if (errors == 0) begin
      $display("** synth_voice_allocator_unit: PASSED **");
    end else begin
      $display("** synth_voice_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sva_pkg.sv
rtl/core/sva_ram.sv
rtl/core/synth_voice_allocator_unit.sv
tb/tb_synth_voice_allocator_unit.sv
